// ----- hdl/accel_temp_comp_window_filter_macros.svh -----
// assertion macros for the accelerometer window filter
`ifndef ACCEL_TEMP_COMP_WINDOW_FILTER_MACROS_SVH
`define ACCEL_TEMP_COMP_WINDOW_FILTER_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ACCF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must follow the antecedent as written
`define ACCF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hdl/accf_pkg.sv -----
// shared types, constants and offset tables for the accelerometer window filter
`default_nettype none

package accf_pkg;

    localparam int WINDOW_TAPS = 9;
    localparam int TEMP_STEPS  = 80;
    localparam int ROM_ROWS    = 80;
    localparam int NUM_AXES    = 3;

    localparam int RAW_W      = 16;
    localparam int SAMP_W     = 22;
    localparam int TEMP_W     = 17;
    localparam int GAIN_W     = 17;
    localparam int BIAS_W     = 19;
    localparam int OFF_W      = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam int SAMP_MAX  = 2097151;
    localparam int SAMP_MIN  = -2097152;
    localparam int SAMP_HALF = 2 ** (SAMP_W - 1);
    localparam int FILT_XW   = SAMP_W + 1;

    // temperature row lookup
    localparam int ROW_W    = $clog2(ROM_ROWS);
    localparam int ROW_MAX  = ((TEMP_STEPS < ROM_ROWS) ? TEMP_STEPS : ROM_ROWS) - 1;
    localparam int ROW_BASE = 30;
    localparam int ROWC_W   = TEMP_W - 8 + 1;

    // temp_q8 = floor((raw*25600 + 1242020*256 + 17000) / 34000), biased positive
    localparam int TMP_MUL    = 100 * 256;
    localparam int TMP_DEN    = 34000;
    localparam int TMP_Q_OFS  = 16384;
    localparam int TMP_ADD    = 1242020 * 256 + TMP_DEN / 2 + TMP_Q_OFS * TMP_DEN;
    localparam int TMP_NW     = 32;
    localparam int TMP_PRE    = 4;
    localparam int TMP_XW     = 27;
    localparam int TMP_MW     = 29;
    localparam int TMP_PW     = TMP_XW + TMP_MW;
    localparam int TMP_DIV_S  = 40;
    localparam int TMP_QW     = 16;
    localparam int TEMP_XW    = TEMP_W + 1;
    localparam logic [TMP_MW-1:0] TMP_DIV_M = 29'd517417237;

    // a = floor((raw*392 + 5) / 10), biased positive
    localparam int SCL_MUL    = 392;
    localparam int SCL_Q_OFS  = 1310720;
    localparam int SCL_ADD    = SCL_Q_OFS * 10 + 5;
    localparam int SCL_VW     = 26;
    localparam int SCL_XW     = 24;
    localparam int DIV5_MW    = 24;
    localparam int DIV5_S     = 26;
    localparam int SCL_PW     = SCL_XW + DIV5_MW;
    localparam int A_XW       = SAMP_W + 1;
    localparam logic [DIV5_MW-1:0] DIV5_M = 24'd13421773;

    // gain and bias
    localparam int GAIN_FRAC  = 16;
    localparam int ROUND_HALF = 2 ** (GAIN_FRAC - 1);
    localparam int DIFF_W     = SAMP_W + 1;
    localparam int P_W        = DIFF_W + GAIN_W + 1;
    localparam int RQ_W       = P_W - GAIN_FRAC;
    localparam int S_XW       = RQ_W + 1;

    // window average: floor((sum + W/2) / W) by reciprocal, biased positive
    localparam int AVG_CLOG = $clog2(WINDOW_TAPS);
    localparam int SUM_W    = SAMP_W + AVG_CLOG;
    localparam int AVG_UW   = SUM_W + 1;
    localparam int AVG_XW   = AVG_UW + 1;
    localparam int AVG_S    = AVG_UW + AVG_CLOG;
    localparam int AVG_MW   = AVG_UW + 2;
    localparam int AVG_PW   = AVG_UW + AVG_MW;
    localparam logic [AVG_MW-1:0] AVG_M =
        AVG_MW'(((64'd1 << AVG_S) + 64'(WINDOW_TAPS - 1)) / 64'(WINDOW_TAPS));
    localparam logic [AVG_UW-1:0] AVG_OFS =
        AVG_UW'(WINDOW_TAPS / 2 + WINDOW_TAPS * SAMP_HALF);

    // configuration
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_X = 3'd0,
        REG_GAIN_Y = 3'd1,
        REG_GAIN_Z = 3'd2,
        REG_BIAS_X = 3'd3,
        REG_BIAS_Y = 3'd4,
        REG_BIAS_Z = 3'd5
    } t_cfg_reg;

    localparam logic [GAIN_W-1:0] GAIN_RST [NUM_AXES] = '{17'd65153, 17'd66017, 17'd64648};
    localparam logic signed [BIAS_W-1:0] BIAS_RST [NUM_AXES] =
        '{-19'sd34880, -19'sd8216, 19'sd47694};

    // step sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_QUOT,
        ST_GAIN,
        ST_BIAS,
        ST_AVG,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic scale;
        logic quot;
        logic gain;
        logic bias;
        logic avg;
        logic out;
    } t_ctl;

    // per-temperature offset tables, Q16 m/s^2
    localparam logic signed [OFF_W-1:0] ROM_X [ROM_ROWS] = '{
        15185, 15849, 16233, 16200, 16601, 17105, 17663, 18009,
        18214, 18635, 19066, 19567, 19710, 20497, 21126, 21704,
        22164, 22529, 23089, 23750, 24103, 24546, 25163, 25666,
        26004, 26195, 26602, 26965, 27212, 27198, 27140, 27522,
        27602, 27482, 27677, 27685, 27700, 27475, 27261, 26964,
        26495, 26077, 25613, 24857, 24460, 24165, 23728, 22820,
        22745, 22430, 21530, 20797, 20439, 20419, 20411, 19635,
        18926, 18174, 17664, 17980, 17528, 17005, 16372, 15666,
        15225, 16119, 15181, 14408, 14071, 13966, 13744, 12953,
        12229, 12369, 11128, 11109, 11534, 10853, 10693, 10339
    };

    localparam logic signed [OFF_W-1:0] ROM_Y [ROM_ROWS] = '{
        -30131, -29873, -29577, -29146, -28444, -27808, -27487, -27347,
        -27138, -26526, -26009, -25621, -25027, -24791, -24204, -23512,
        -23431, -23130, -22361, -21972, -21240, -20835, -20974, -20688,
        -20374, -20207, -20198, -20204, -20188, -20074, -19942, -19866,
        -19680, -19832, -19607, -19402, -19371, -19645, -19579, -19362,
        -19428, -19544, -19464, -18909, -18923, -19075, -19018, -19044,
        -18567, -18170, -18734, -18595, -18558, -18457, -18566, -18205,
        -17800, -17744, -17999, -18206, -17906, -18013, -17435, -17549,
        -16820, -16717, -17580, -17153, -17253, -17203, -16796, -16694,
        -16720, -16327, -16178, -16118, -15914, -15990, -16035, -15728
    };

    localparam logic signed [OFF_W-1:0] ROM_Z [ROM_ROWS] = '{
        106450, 103965, 99586, 94600, 89898, 85928, 80941, 75025,
        70116, 65245, 59798, 53604, 47428, 42131, 36879, 31298,
        25513, 20598, 15754, 11143, 6983, 3511, 606, -1901,
        -4892, -7078, -10587, -12977, -14344, -15484, -17436, -18902,
        -18745, -19016, -18795, -19088, -18684, -18098, -17202, -15697,
        -15387, -14635, -13116, -12242, -10934, -10533, -9408, -8443,
        -7717, -7317, -6842, -6090, -5148, -4941, -5077, -3977,
        -3000, -2699, -2443, -2238, -1199, -352, -592, 232,
        -350, 886, 1609, 2806, 2686, 3188, 3788, 4326,
        4969, 5256, 5971, 6204, 6242, 6900, 7794, 8122
    };

endpackage

`default_nettype wire

// ----- hdl/accf_temp.sv -----
// temperature conversion to Q8 degrees and offset table row selection
`default_nettype none

module accf_temp import accf_pkg::*; (
    input  logic                     i_clk,
    input  t_ctl                     i_ctl,
    input  logic signed [RAW_W-1:0]  i_raw_temp,
    output logic signed [TEMP_W-1:0] o_temp_q8,
    output logic [ROW_W-1:0]         o_row
);

    logic signed [RAW_W-1:0]  r_raw;
    logic [TMP_PW-1:0]        r_prod;
    logic signed [TEMP_W-1:0] r_temp;
    logic [ROW_W-1:0]         r_row;

    logic signed [TMP_NW-1:0]  num;
    logic [TMP_XW-1:0]         num_sh;
    logic [TMP_PW-1:0]         n_prod;
    logic [TMP_QW-1:0]         quo;
    logic signed [TEMP_XW-1:0] tq;
    logic signed [TEMP_W-1:0]  n_temp;
    logic signed [ROWC_W-1:0]  rowc;
    logic [ROW_W-1:0]          n_row;

    always_comb begin
        num    = TMP_NW'(r_raw) * TMP_NW'(TMP_MUL) + TMP_NW'(TMP_ADD);
        num_sh = num[TMP_XW+TMP_PRE-1:TMP_PRE];
        n_prod = TMP_PW'(num_sh) * TMP_PW'(TMP_DIV_M);

        quo    = r_prod[TMP_DIV_S +: TMP_QW];
        tq     = TEMP_XW'($signed({2'b00, quo})) - TEMP_XW'(TMP_Q_OFS);
        n_temp = tq[TEMP_W-1:0];

        // whole degrees plus table base, clamped to the table
        rowc = ROWC_W'($signed(n_temp[TEMP_W-1:8])) + ROWC_W'(ROW_BASE);
        if (rowc < $signed(ROWC_W'(0))) begin
            n_row = '0;
        end else if (rowc > $signed(ROWC_W'(ROW_MAX))) begin
            n_row = ROW_W'(ROW_MAX);
        end else begin
            n_row = rowc[ROW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_raw <= i_raw_temp;
        end
        if (i_ctl.scale) begin
            r_prod <= n_prod;
        end
        if (i_ctl.quot) begin
            r_temp <= n_temp;
            r_row  <= n_row;
        end
    end

    assign o_temp_q8 = r_temp;
    assign o_row     = r_row;

endmodule

`default_nettype wire

// ----- hdl/accf_lane.sv -----
// one axis lane: scaling, offset removal, gain and bias, window average
`default_nettype none

module accf_lane import accf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctl                     i_ctl,
    input  logic signed [RAW_W-1:0]  i_raw,
    input  logic signed [OFF_W-1:0]  i_offset,
    input  logic [GAIN_W-1:0]        i_gain,
    input  logic signed [BIAS_W-1:0] i_bias,
    output logic signed [SAMP_W-1:0] o_filt
);

    logic signed [RAW_W-1:0]  r_raw;
    logic [SCL_PW-1:0]        r_prod1;
    logic signed [SAMP_W-1:0] r_a;
    logic signed [P_W-1:0]    r_p;
    logic signed [SAMP_W-1:0] r_s;
    logic [AVG_PW-1:0]        r_prod2;
    logic signed [SAMP_W-1:0] r_filt;
    logic signed [SAMP_W-1:0] r_line [WINDOW_TAPS-1];
    logic signed [SUM_W-1:0]  r_sum;

    logic signed [SCL_VW-1:0] v;
    logic [SCL_PW-1:0]        n_prod1;
    logic [SAMP_W-1:0]        q5;
    logic signed [A_XW-1:0]   a_x;
    logic signed [DIFF_W-1:0] diff;
    logic signed [P_W-1:0]    n_p;
    logic signed [P_W-1:0]    p_rnd;
    logic signed [RQ_W-1:0]   rq;
    logic signed [S_XW-1:0]   s_full;
    logic signed [SAMP_W-1:0] n_s;
    logic signed [SUM_W-1:0]  total;
    logic [AVG_XW-1:0]        u_x;
    logic [AVG_PW-1:0]        n_prod2;
    logic [SAMP_W-1:0]        qa;
    logic signed [FILT_XW-1:0] filt_x;

    always_comb begin
        // counts to Q16 m/s^2, divide by ten as halve then reciprocal of five
        v       = SCL_VW'(r_raw) * SCL_VW'(SCL_MUL) + SCL_VW'(SCL_ADD);
        n_prod1 = SCL_PW'(v[SCL_XW:1]) * SCL_PW'(DIV5_M);
        q5      = r_prod1[DIV5_S +: SAMP_W];
        a_x     = A_XW'($signed({1'b0, q5})) - A_XW'(SCL_Q_OFS);

        diff  = DIFF_W'(r_a) - DIFF_W'(i_offset);
        n_p   = P_W'(diff) * P_W'($signed({1'b0, i_gain}));

        p_rnd  = r_p + P_W'(ROUND_HALF);
        rq     = p_rnd[P_W-1:GAIN_FRAC];
        s_full = S_XW'(rq) + S_XW'(i_bias);
        if (s_full > $signed(S_XW'(SAMP_MAX))) begin
            n_s = SAMP_W'(SAMP_MAX);
        end else if (s_full < $signed(S_XW'(SAMP_MIN))) begin
            n_s = SAMP_W'(SAMP_MIN);
        end else begin
            n_s = s_full[SAMP_W-1:0];
        end

        total   = SUM_W'(r_s) + r_sum;
        u_x     = AVG_XW'(total) + AVG_XW'(AVG_OFS);
        n_prod2 = AVG_PW'(u_x[AVG_UW-1:0]) * AVG_PW'(AVG_M);
        qa      = r_prod2[AVG_S +: SAMP_W];
        filt_x  = FILT_XW'($signed({1'b0, qa})) - FILT_XW'(SAMP_HALF);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_raw <= i_raw;
        end
        if (i_ctl.scale) begin
            r_prod1 <= n_prod1;
        end
        if (i_ctl.quot) begin
            r_a <= a_x[SAMP_W-1:0];
        end
        if (i_ctl.gain) begin
            r_p <= n_p;
        end
        if (i_ctl.bias) begin
            r_s <= n_s;
        end
        if (i_ctl.avg) begin
            r_prod2 <= n_prod2;
        end
        if (i_ctl.out) begin
            r_filt <= filt_x[SAMP_W-1:0];
        end
    end

    // window history and running sum of the stored samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_TAPS - 1; k++) begin
                r_line[k] <= '0;
            end
            r_sum <= '0;
        end else if (i_ctl.avg) begin
            r_line[0] <= r_s;
            for (int k = 1; k < WINDOW_TAPS - 1; k++) begin
                r_line[k] <= r_line[k-1];
            end
            r_sum <= r_sum + SUM_W'(r_s) - SUM_W'(r_line[WINDOW_TAPS-2]);
        end
    end

    assign o_filt = r_filt;

endmodule

`default_nettype wire

// ----- hdl/accel_temp_comp_window_filter.sv -----
// Temperature-compensated accelerometer calibrator with a moving-average window.
// Each item is one sensor frame; three axis lanes work on it side by side while a
// shared temperature unit picks the offset table row. A step sequencer drives all
// lanes through scale, divide, gain, bias and average steps, at most one multiply
// per step; the result becomes valid as o_in_ready returns, so a new item is taken
// only once the previous one has finished its steps. The finished
// result sits in the output register, so the next item is taken while it waits; a
// result that is still not taken holds the following item at its final step. The
// window holds the last 8 calibrated samples per axis and starts at zero after reset.
// Configuration writes go to i_cfg_idx 0..5 (gain x/y/z, bias x/y/z); other indexes
// are ignored.
`default_nettype none
`include "accel_temp_comp_window_filter_macros.svh"

module accel_temp_comp_window_filter import accf_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [RAW_W-1:0]     i_raw_accel_x,
    input  logic signed [RAW_W-1:0]     i_raw_accel_y,
    input  logic signed [RAW_W-1:0]     i_raw_accel_z,
    input  logic signed [RAW_W-1:0]     i_raw_temp,

    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [SAMP_W-1:0]    o_filt_x,
    output logic signed [SAMP_W-1:0]    o_filt_y,
    output logic signed [SAMP_W-1:0]    o_filt_z,
    output logic signed [TEMP_W-1:0]    o_temp_c,

    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data
);

    t_state r_state;
    t_state n_state;
    t_ctl   ctl;

    logic                     r_out_valid;
    logic signed [TEMP_W-1:0] r_temp_c;
    logic [GAIN_W-1:0]        r_gain [NUM_AXES];
    logic signed [BIAS_W-1:0] r_bias [NUM_AXES];

    logic signed [TEMP_W-1:0] temp_q8;
    logic [ROW_W-1:0]         row;
    logic signed [RAW_W-1:0]  raw_ax  [NUM_AXES];
    logic signed [OFF_W-1:0]  off_ax  [NUM_AXES];
    logic signed [SAMP_W-1:0] filt_ax [NUM_AXES];
    logic                     out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // step sequencer
    always_comb begin
        n_state    = r_state;
        ctl        = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    ctl.load = 1'b1;
                    n_state  = ST_SCALE;
                end
            end
            ST_SCALE: begin
                ctl.scale = 1'b1;
                n_state   = ST_QUOT;
            end
            ST_QUOT: begin
                ctl.quot = 1'b1;
                n_state  = ST_GAIN;
            end
            ST_GAIN: begin
                ctl.gain = 1'b1;
                n_state  = ST_BIAS;
            end
            ST_BIAS: begin
                ctl.bias = 1'b1;
                n_state  = ST_AVG;
            end
            ST_AVG: begin
                ctl.avg = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    ctl.out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctl.out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.out) begin
            r_temp_c <= temp_q8;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_gain[k] <= GAIN_RST[k];
                r_bias[k] <= BIAS_RST[k];
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_GAIN_X: r_gain[0] <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_Y: r_gain[1] <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_Z: r_gain[2] <= i_cfg_data[GAIN_W-1:0];
                REG_BIAS_X: r_bias[0] <= i_cfg_data[BIAS_W-1:0];
                REG_BIAS_Y: r_bias[1] <= i_cfg_data[BIAS_W-1:0];
                REG_BIAS_Z: r_bias[2] <= i_cfg_data[BIAS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    accf_temp u_temp (
        .i_clk      (i_clk),
        .i_ctl      (ctl),
        .i_raw_temp (i_raw_temp),
        .o_temp_q8  (temp_q8),
        .o_row      (row)
    );

    assign raw_ax[0] = i_raw_accel_x;
    assign raw_ax[1] = i_raw_accel_y;
    assign raw_ax[2] = i_raw_accel_z;

    assign off_ax[0] = ROM_X[row];
    assign off_ax[1] = ROM_Y[row];
    assign off_ax[2] = ROM_Z[row];

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        accf_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_raw    (raw_ax[g]),
            .i_offset (off_ax[g]),
            .i_gain   (r_gain[g]),
            .i_bias   (r_bias[g]),
            .o_filt   (filt_ax[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_filt_x    = filt_ax[0];
    assign o_filt_y    = filt_ax[1];
    assign o_filt_z    = filt_ax[2];
    assign o_temp_c    = r_temp_c;

    `ACCF_ASSERT_ALWAYS(a_ctl_single_step, i_clk, i_rst_n, $onehot0(ctl), "two steps at once")
    `ACCF_ASSERT_IMPLY(a_accept_to_avg, i_clk, i_rst_n, i_in_valid && o_in_ready, ##5 (r_state == ST_AVG), "item missed its average step")
    `ACCF_ASSERT_IMPLY(a_stall_holds, i_clk, i_rst_n, r_out_valid && !i_out_ready && (r_state == ST_OUT), ##1 (r_state == ST_OUT), "finished item left while output stalled")

endmodule

`default_nettype wire
